FILE: rtl/load_store_register_unit_macros.svh
// ----------------------------------------------------------------------------
// load_store_register_unit_macros
// Assertion macros for the load/store register unit checker.
// ----------------------------------------------------------------------------
`ifndef LOAD_STORE_REGISTER_UNIT_MACROS_SVH
`define LOAD_STORE_REGISTER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while reset is low.
`define LSRU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on i_clk, off while reset is low.
`define LSRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lsru_pkg.sv
// ----------------------------------------------------------------------------
// lsru_pkg
// Opcode codes and field widths for the load/store register unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsru_pkg;

    localparam int OpWidth   = 4;
    localparam int ByteWidth = 8;
    localparam int AddrWidth = 16;
    localparam int SignBit   = 7;

    typedef logic [OpWidth-1:0]   t_opcode;
    typedef logic [ByteWidth-1:0] t_byte;
    typedef logic [AddrWidth-1:0] t_addr;

    localparam t_opcode OP_LDA = 4'd0;
    localparam t_opcode OP_LDX = 4'd1;
    localparam t_opcode OP_LDY = 4'd2;
    localparam t_opcode OP_LAX = 4'd3;
    localparam t_opcode OP_STA = 4'd4;
    localparam t_opcode OP_STX = 4'd5;
    localparam t_opcode OP_STY = 4'd6;
    localparam t_opcode OP_LAS = 4'd7;
    localparam t_opcode OP_SHX = 4'd8;
    localparam t_opcode OP_SHY = 4'd9;
    localparam t_opcode OP_SHA = 4'd10;
    localparam t_opcode OP_SAX = 4'd11;

endpackage

`default_nettype wire

FILE: rtl/load_store_register_unit.sv
// An accepted transaction's result shows on the output in the next cycle.
// Throughput: one transaction per cycle unless the output stalls; the update is
// AND gates, a 16-bit increment, a 16-bit subtract and muxes, all in one pass.
// The output register frees itself in the same cycle it is taken downstream.
// Reset (synchronous, active low) clears A, X, Y, S, N, Z and the output valid.
// ----------------------------------------------------------------------------
// load_store_register_unit
// Executes one 6502-style load or store instruction, undocumented variants
// included, against A, X, Y, S and the N/Z flags; reports the memory write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module load_store_register_unit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // input channel
    input  wire                  i_valid,
    output logic                 o_stall,
    input  lsru_pkg::t_opcode    i_opcode,
    input  lsru_pkg::t_byte      i_data_byte,
    input  lsru_pkg::t_addr      i_eff_addr,
    input  wire                  i_abs_y_mode,
    // output channel
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic                 o_mem_write,
    output lsru_pkg::t_addr      o_write_addr,
    output lsru_pkg::t_byte      o_write_data,
    output lsru_pkg::t_byte      o_acc_out,
    output lsru_pkg::t_byte      o_xreg_out,
    output lsru_pkg::t_byte      o_yreg_out,
    output lsru_pkg::t_byte      o_sp_out,
    output logic                 o_neg_flag,
    output logic                 o_zero_flag
);
    import lsru_pkg::*;

    // architectural state
    t_byte r_accum, n_accum;
    t_byte r_index_x, n_index_x;
    t_byte r_index_y, n_index_y;
    t_byte r_stack_ptr, n_stack_ptr;
    logic  r_neg_bit, n_neg_bit;
    logic  r_zero_bit, n_zero_bit;

    // result register
    logic  r_valid;
    logic  r_mem_write, n_mem_write;
    t_addr r_write_addr, n_write_addr;
    t_byte r_write_data, n_write_data;

    logic  w_accept;
    t_addr w_addr_inc;
    t_addr w_sha_base;
    t_byte w_shx_high;
    t_byte w_shy_high;
    t_byte w_sha_high;
    t_byte w_sha_op;
    t_byte w_load_val;
    logic  w_load;

    // Hold the input off while a result waits downstream, and during reset.
    assign o_stall  = !i_rst_n || (r_valid && i_stall);
    assign w_accept = i_valid && !o_stall;

    // High bytes for the unstable stores, formed as the hardware forms them.
    assign w_addr_inc = i_eff_addr + t_addr'(1);
    assign w_shx_high = w_addr_inc[AddrWidth-1 -: ByteWidth];
    assign w_shy_high = i_eff_addr[AddrWidth-1 -: ByteWidth] + t_byte'(1);
    // Recover the base address for absolute-Y, then bump its high byte.
    assign w_sha_base = i_eff_addr - {{(AddrWidth-ByteWidth){1'b0}}, r_index_y};
    assign w_sha_high = w_sha_base[AddrWidth-1 -: ByteWidth] + t_byte'(1);
    assign w_sha_op   = i_abs_y_mode ? w_sha_high : i_data_byte;

    always_comb begin
        n_accum      = r_accum;
        n_index_x    = r_index_x;
        n_index_y    = r_index_y;
        n_stack_ptr  = r_stack_ptr;
        n_mem_write  = 1'b0;
        n_write_data = '0;
        w_load       = 1'b0;
        w_load_val   = i_data_byte;
        case (i_opcode)
            OP_LDA: begin
                n_accum = i_data_byte;
                w_load  = 1'b1;
            end
            OP_LDX: begin
                n_index_x = i_data_byte;
                w_load    = 1'b1;
            end
            OP_LDY: begin
                n_index_y = i_data_byte;
                w_load    = 1'b1;
            end
            OP_LAX: begin
                n_accum   = i_data_byte;
                n_index_x = i_data_byte;
                w_load    = 1'b1;
            end
            OP_LAS: begin
                w_load_val  = r_stack_ptr & i_data_byte;
                n_accum     = w_load_val;
                n_index_x   = w_load_val;
                n_stack_ptr = w_load_val;
                w_load      = 1'b1;
            end
            OP_STA: begin
                n_mem_write  = 1'b1;
                n_write_data = r_accum;
            end
            OP_STX: begin
                n_mem_write  = 1'b1;
                n_write_data = r_index_x;
            end
            OP_STY: begin
                n_mem_write  = 1'b1;
                n_write_data = r_index_y;
            end
            OP_SHX: begin
                n_mem_write  = 1'b1;
                n_write_data = r_index_x & w_shx_high;
            end
            OP_SHY: begin
                n_mem_write  = 1'b1;
                n_write_data = r_index_y & w_shy_high;
            end
            OP_SHA: begin
                n_mem_write  = 1'b1;
                n_write_data = r_accum & r_index_x & w_sha_op;
            end
            OP_SAX: begin
                n_mem_write  = 1'b1;
                n_write_data = r_accum & r_index_x;
            end
            default: begin
                // unused codes: no write, state unchanged
            end
        endcase
        // Stores leave the flags alone.
        n_neg_bit    = w_load ? w_load_val[SignBit] : r_neg_bit;
        n_zero_bit   = w_load ? (w_load_val == '0) : r_zero_bit;
        n_write_addr = n_mem_write ? i_eff_addr : '0;
    end

    // Architectural state advances only on accept; valid also clears when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_accum     <= '0;
            r_index_x   <= '0;
            r_index_y   <= '0;
            r_stack_ptr <= '0;
            r_neg_bit   <= 1'b0;
            r_zero_bit  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_valid     <= 1'b1;
                r_accum     <= n_accum;
                r_index_x   <= n_index_x;
                r_index_y   <= n_index_y;
                r_stack_ptr <= n_stack_ptr;
                r_neg_bit   <= n_neg_bit;
                r_zero_bit  <= n_zero_bit;
            end else if (!i_stall) begin
                // result taken, nothing new behind it: drop valid
                r_valid <= 1'b0;
            end
        end
    end

    // Write payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem_write  <= n_mem_write;
            r_write_addr <= n_write_addr;
            r_write_data <= n_write_data;
        end
    end

    // Register outputs come straight from state; it only moves on accept,
    // so a stalled result holds.
    assign o_valid      = r_valid;
    assign o_mem_write  = r_mem_write;
    assign o_write_addr = r_write_addr;
    assign o_write_data = r_write_data;
    assign o_acc_out    = r_accum;
    assign o_xreg_out   = r_index_x;
    assign o_yreg_out   = r_index_y;
    assign o_sp_out     = r_stack_ptr;
    assign o_neg_flag   = r_neg_bit;
    assign o_zero_flag  = r_zero_bit;

endmodule

`default_nettype wire

FILE: rtl/lsru_checker.sv
// ----------------------------------------------------------------------------
// lsru_checker
// Port-level checks for the load/store register unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "load_store_register_unit_macros.svh"

module lsru_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_valid,
    input wire                  o_stall,
    input lsru_pkg::t_opcode    i_opcode,
    input lsru_pkg::t_byte      i_data_byte,
    input wire                  o_valid,
    input wire                  i_stall,
    input wire                  o_mem_write,
    input lsru_pkg::t_addr      o_write_addr,
    input lsru_pkg::t_byte      o_write_data,
    input lsru_pkg::t_byte      o_acc_out,
    input wire                  o_zero_flag
);
    import lsru_pkg::*;

    logic w_in_acc;
    assign w_in_acc = i_valid && !o_stall;

    // A stalled result holds.
    `LSRU_ASSERT_NEXT(a_hold, o_valid && i_stall, o_valid && $stable(o_write_data) && $stable(o_acc_out), "stalled result changed")
    // No write means zero address and data.
    `LSRU_ASSERT_NOW(a_nowrite, o_valid && !o_mem_write, o_write_addr == '0 && o_write_data == '0, "idle write fields not zero")
    // LDA lands in A with the zero flag from the byte.
    `LSRU_ASSERT_NEXT(a_lda, w_in_acc && i_opcode == OP_LDA, o_valid && o_acc_out == $past(i_data_byte) && o_zero_flag == ($past(i_data_byte) == '0), "LDA result wrong")
    // STA writes the accumulator it leaves unchanged.
    `LSRU_ASSERT_NEXT(a_sta, w_in_acc && i_opcode == OP_STA, o_mem_write && o_write_data == o_acc_out, "STA data differs from A")
    // Out of reset, the input stalls only behind a waiting result.
    `LSRU_ASSERT_NOW(a_stall, o_stall, o_valid && i_stall, "input stalled with output free")

endmodule

bind load_store_register_unit lsru_checker u_lsru_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_opcode     (i_opcode),
    .i_data_byte  (i_data_byte),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_mem_write  (o_mem_write),
    .o_write_addr (o_write_addr),
    .o_write_data (o_write_data),
    .o_acc_out    (o_acc_out),
    .o_zero_flag  (o_zero_flag)
);

`default_nettype wire
